@@ hw/rtl/gng_pkg.sv @@
// Constants, tables and state type for the gaussian noise generator.
package gng_pkg;

  localparam int MAX_COUNT_DEF = 64;
  localparam int FRAC_BITS = 16;

  // -2 ln u stays below 44.0, so it needs FRAC_BITS + 6 bits
  localparam int V_W = FRAC_BITS + 6;
  localparam int SQ_ITER = FRAC_BITS + 3;
  localparam int RAD_W = 2 * SQ_ITER;
  localparam int IT_W = $clog2(SQ_ITER);
  localparam int Q_W = FRAC_BITS + 5;

  localparam logic [31:0] LCG_MOD = 32'd2147483647;
  localparam logic [31:0] LCG_MUL = 32'd16807;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  // 2 ln 2 rounded from Q30 to Q.FRAC_BITS
  localparam logic [31:0] LN_C =
    32'((64'd1488522236 + ((64'd1 << (30 - FRAC_BITS)) >> 1)) >> (30 - FRAC_BITS));

  // Exact floor division by the Taylor denominators: ceil(2^S/d), shift S.
  // Entries 0..3 build sin (72 42 20 6), entries 4..8 build cos (90 56 30 12 2).
  localparam logic [31:0] RECIP [9] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };
  localparam logic [5:0] RSHIFT [9] = '{
    6'd37, 6'd36, 6'd35, 6'd33, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
  };
  localparam logic [3:0] K_SIN_END = 4'd3;
  localparam logic [3:0] K_COS_END = 4'd8;

  localparam logic [1:0] CFG_MEAN = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_U1_MUL, ST_U1_RED, ST_U2_MUL, ST_U2_RED, ST_NORM,
    ST_SQ_MUL, ST_SQ_UPD, ST_LN_Q, ST_LN_MUL, ST_LN_RED, ST_SQRT,
    ST_ANG_MUL, ST_ANG_X, ST_X2_MUL, ST_X2, ST_P_MUL1, ST_P_Y, ST_P_MUL2,
    ST_P_T, ST_S_MUL, ST_S_SAVE, ST_MAP, ST_Z_MUL, ST_Z, ST_T_MUL,
    ST_SHAPE, ST_EMIT_C, ST_EMIT_S
  } state_t;

endpackage

@@ hw/rtl/gaussian_noise_generator_core.sv @@
// Gaussian noise generator: LCG uniforms into a Box-Muller transform on one shared multiplier.
//
// Input stream: tuser = 0 reseeds (seed in tdata[30:0]; 0 or 2^31-1 loads 1),
// tuser = 1 requests count samples (tdata[37:31], clamped to MAX_COUNT).
// A reseed gives no output; a request of count 0 gives none.
// Output stream: one signed Q15.16 sample per beat, cosine then sine of each
// pair, tlast on the final sample of the request; an odd count drops the sine.
// Configuration: cfg_index 0 writes mean (Q15.16), 1 writes scale (Q8.16).
// Each pair runs through a sequencer around a single 32x32 multiplier with a
// registered product: normalize, 16 squaring rounds, a 19-step square root,
// nine Taylor steps, then two scalings.
// tready is high only between requests. The output register holds one sample;
// while the receiver stalls the sequencer waits at the emit step.
// Reset loads seed 1, mean 0, scale 1.0 and drops any pending output.
module gaussian_noise_generator_core #(
  parameter int MAX_COUNT = gng_pkg::MAX_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // seed_value[30:0], count[37:31], zero pad
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // sample[31:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int F = gng_pkg::FRAC_BITS;
  localparam int SQI = gng_pkg::SQ_ITER;

  gng_pkg::state_t state, state_next;

  logic [30:0] seed, u2, m;
  logic [4:0]  e;
  logic [F-1:0] frac;
  logic [gng_pkg::Q_W-1:0] qv;
  logic [gng_pkg::IT_W-1:0] it;
  logic [gng_pkg::RAD_W-1:0] rad;
  logic [SQI-1:0] root;
  logic [SQI+1:0] rem;
  logic [29:0] x, x2, y;
  logic [30:0] t, sv, cmag, smag;
  logic        cneg, sneg, sel;
  logic [3:0]  k;
  logic [SQI-1:0] z;
  logic [31:0] cos_res, held;
  logic [6:0]  cnt;
  logic [31:0] mean;
  logic [23:0] scale;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;

  logic        out_free;
  logic        emit;
  logic [6:0]  cnt_in;
  logic [30:0] seed_in, red;
  logic [31:0] red_sum;
  logic [28:0] g;
  logic [31:0] sq;
  logic [SQI+1:0] rem_sh, trial;
  logic [30:0] tn;
  logic [30:0] c0, s0;
  logic [33:0] term, sum;
  logic [31:0] res;
  logic        mneg;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit = (state == gng_pkg::ST_EMIT_C || state == gng_pkg::ST_EMIT_S) && out_free;

  // datapath helpers
  always_comb begin
    cnt_in = (int'(s_axis_tdata[37:31]) > MAX_COUNT) ? 7'(MAX_COUNT) : s_axis_tdata[37:31];
    seed_in = s_axis_tdata[30:0];
    if (seed_in == 31'd0 || seed_in == 31'h7FFFFFFF) begin
      seed_in = 31'd1;
    end
    // s*16807 mod 2^31-1 by folding the high part back in
    red_sum = {1'b0, prod[30:0]} + {1'b0, prod[61:31]};
    red = (red_sum >= gng_pkg::LCG_MOD) ? 31'(red_sum - gng_pkg::LCG_MOD) : red_sum[30:0];
    g = u2[28] ? (29'h10000000 - {1'b0, u2[27:0]}) : {1'b0, u2[27:0]};
    sq = prod[61:30];
    rem_sh = {rem[SQI-1:0], rad[gng_pkg::RAD_W-1 -: 2]};
    trial = {root, 2'b01};
    tn = gng_pkg::Q30_ONE - 31'(prod >> gng_pkg::RSHIFT[k]);
    c0 = u2[28] ? sv : t;
    s0 = u2[28] ? t : sv;
    mneg = sel ? sneg : cneg;
    term = 34'(prod >> F);
    sum = {{2{mean[31]}}, mean} + (mneg ? (34'd0 - term) : term);
    if (!sum[33] && sum[32:31] != 2'b00) begin
      res = 32'h7FFFFFFF;
    end else if (sum[33] && sum[32:31] != 2'b11) begin
      res = 32'h80000000;
    end else begin
      res = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gng_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser && cnt_in != 7'd0) begin
          state_next = gng_pkg::ST_U1_MUL;
        end
      end
      gng_pkg::ST_U1_MUL:  state_next = gng_pkg::ST_U1_RED;
      gng_pkg::ST_U1_RED:  state_next = gng_pkg::ST_U2_MUL;
      gng_pkg::ST_U2_MUL:  state_next = gng_pkg::ST_U2_RED;
      gng_pkg::ST_U2_RED:  state_next = gng_pkg::ST_NORM;
      gng_pkg::ST_NORM: begin
        if (m[30]) begin
          state_next = gng_pkg::ST_SQ_MUL;
        end
      end
      gng_pkg::ST_SQ_MUL:  state_next = gng_pkg::ST_SQ_UPD;
      gng_pkg::ST_SQ_UPD: begin
        state_next = (it == gng_pkg::IT_W'(F - 1)) ? gng_pkg::ST_LN_Q : gng_pkg::ST_SQ_MUL;
      end
      gng_pkg::ST_LN_Q:    state_next = gng_pkg::ST_LN_MUL;
      gng_pkg::ST_LN_MUL:  state_next = gng_pkg::ST_LN_RED;
      gng_pkg::ST_LN_RED:  state_next = gng_pkg::ST_SQRT;
      gng_pkg::ST_SQRT: begin
        if (it == gng_pkg::IT_W'(SQI - 1)) begin
          state_next = gng_pkg::ST_ANG_MUL;
        end
      end
      gng_pkg::ST_ANG_MUL: state_next = gng_pkg::ST_ANG_X;
      gng_pkg::ST_ANG_X:   state_next = gng_pkg::ST_X2_MUL;
      gng_pkg::ST_X2_MUL:  state_next = gng_pkg::ST_X2;
      gng_pkg::ST_X2:      state_next = gng_pkg::ST_P_MUL1;
      gng_pkg::ST_P_MUL1:  state_next = gng_pkg::ST_P_Y;
      gng_pkg::ST_P_Y:     state_next = gng_pkg::ST_P_MUL2;
      gng_pkg::ST_P_MUL2:  state_next = gng_pkg::ST_P_T;
      gng_pkg::ST_P_T: begin
        if (k == gng_pkg::K_SIN_END) begin
          state_next = gng_pkg::ST_S_MUL;
        end else if (k == gng_pkg::K_COS_END) begin
          state_next = gng_pkg::ST_MAP;
        end else begin
          state_next = gng_pkg::ST_P_MUL1;
        end
      end
      gng_pkg::ST_S_MUL:   state_next = gng_pkg::ST_S_SAVE;
      gng_pkg::ST_S_SAVE:  state_next = gng_pkg::ST_P_MUL1;
      gng_pkg::ST_MAP:     state_next = gng_pkg::ST_Z_MUL;
      gng_pkg::ST_Z_MUL:   state_next = gng_pkg::ST_Z;
      gng_pkg::ST_Z:       state_next = gng_pkg::ST_T_MUL;
      gng_pkg::ST_T_MUL:   state_next = gng_pkg::ST_SHAPE;
      gng_pkg::ST_SHAPE:   state_next = sel ? gng_pkg::ST_EMIT_C : gng_pkg::ST_Z_MUL;
      gng_pkg::ST_EMIT_C: begin
        if (out_free) begin
          state_next = (cnt == 7'd1) ? gng_pkg::ST_IDLE : gng_pkg::ST_EMIT_S;
        end
      end
      gng_pkg::ST_EMIT_S: begin
        if (out_free) begin
          state_next = (cnt == 7'd1) ? gng_pkg::ST_IDLE : gng_pkg::ST_U1_MUL;
        end
      end
      default: state_next = gng_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operand select
  always_comb begin
    s_axis_tready = (state == gng_pkg::ST_IDLE);
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      gng_pkg::ST_U1_MUL, gng_pkg::ST_U2_MUL: begin
        mul_a = {1'b0, seed};
        mul_b = gng_pkg::LCG_MUL;
      end
      gng_pkg::ST_SQ_MUL: begin
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      gng_pkg::ST_LN_MUL: begin
        mul_a = 32'(qv);
        mul_b = gng_pkg::LN_C;
      end
      gng_pkg::ST_ANG_MUL: begin
        mul_a = 32'(g);
        mul_b = gng_pkg::PI_Q30;
      end
      gng_pkg::ST_X2_MUL: begin
        mul_a = {2'b0, x};
        mul_b = {2'b0, x};
      end
      gng_pkg::ST_P_MUL1: begin
        mul_a = {2'b0, x2};
        mul_b = {1'b0, t};
      end
      gng_pkg::ST_P_MUL2: begin
        mul_a = {2'b0, y};
        mul_b = gng_pkg::RECIP[k];
      end
      gng_pkg::ST_S_MUL: begin
        mul_a = {2'b0, x};
        mul_b = {1'b0, t};
      end
      gng_pkg::ST_Z_MUL: begin
        mul_a = 32'(root);
        mul_b = {1'b0, sel ? smag : cmag};
      end
      gng_pkg::ST_T_MUL: begin
        mul_a = {8'b0, scale};
        mul_b = 32'(z);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gng_pkg::ST_IDLE;
      seed <= 31'd1;
      cnt <= 7'd0;
      mean <= 32'd0;
      scale <= 24'd65536;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if ({1'b0, cfg_index} == gng_pkg::CFG_MEAN) begin
          mean <= cfg_data;
        end else if ({1'b0, cfg_index} == gng_pkg::CFG_SCALE) begin
          scale <= cfg_data[23:0];
        end
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        gng_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (!s_axis_tuser) begin
              seed <= seed_in;
            end else begin
              cnt <= cnt_in;
            end
          end
        end
        gng_pkg::ST_U1_RED, gng_pkg::ST_U2_RED: seed <= red;
        gng_pkg::ST_EMIT_C, gng_pkg::ST_EMIT_S: begin
          if (out_free) begin
            cnt <= cnt - 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      gng_pkg::ST_U1_RED: begin
        m <= red;
        e <= 5'd1;
      end
      gng_pkg::ST_U2_RED: begin
        u2 <= red;
        it <= '0;
        frac <= '0;
      end
      gng_pkg::ST_NORM: begin
        if (!m[30]) begin
          m <= {m[29:0], 1'b0};
          e <= e + 5'd1;
        end
      end
      gng_pkg::ST_SQ_UPD: begin
        frac <= {frac[F-2:0], sq[31]};
        m <= sq[31] ? sq[31:1] : sq[30:0];
        it <= it + 1'b1;
      end
      gng_pkg::ST_LN_Q: qv <= {e, {F{1'b0}}} - gng_pkg::Q_W'(frac);
      gng_pkg::ST_LN_RED: begin
        rad <= {prod[F +: gng_pkg::V_W], {F{1'b0}}};
        root <= '0;
        rem <= '0;
        it <= '0;
      end
      gng_pkg::ST_SQRT: begin
        rad <= {rad[gng_pkg::RAD_W-3:0], 2'b00};
        it <= it + 1'b1;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[SQI-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[SQI-2:0], 1'b0};
        end
      end
      gng_pkg::ST_ANG_X: x <= prod[59:30];
      gng_pkg::ST_X2: begin
        x2 <= prod[59:30];
        t <= gng_pkg::Q30_ONE;
        k <= 4'd0;
      end
      gng_pkg::ST_P_Y: y <= prod[59:30];
      gng_pkg::ST_P_T: begin
        t <= tn;
        if (k != gng_pkg::K_COS_END) begin
          k <= k + 4'd1;
        end
      end
      gng_pkg::ST_S_SAVE: begin
        sv <= prod[60:30];
        t <= gng_pkg::Q30_ONE;
      end
      gng_pkg::ST_MAP: begin
        sel <= 1'b0;
        case (u2[30:29])
          2'd0: begin
            cmag <= c0; cneg <= 1'b0; smag <= s0; sneg <= 1'b0;
          end
          2'd1: begin
            cmag <= s0; cneg <= 1'b1; smag <= c0; sneg <= 1'b0;
          end
          2'd2: begin
            cmag <= c0; cneg <= 1'b1; smag <= s0; sneg <= 1'b1;
          end
          default: begin
            cmag <= s0; cneg <= 1'b0; smag <= c0; sneg <= 1'b1;
          end
        endcase
      end
      gng_pkg::ST_Z: z <= prod[30 +: SQI];
      gng_pkg::ST_SHAPE: begin
        if (!sel) begin
          cos_res <= res;
          sel <= 1'b1;
        end else begin
          held <= res;
        end
      end
      gng_pkg::ST_EMIT_C: begin
        if (out_free) begin
          m_axis_tdata <= cos_res;
          m_axis_tlast <= (cnt == 7'd1);
        end
      end
      gng_pkg::ST_EMIT_S: begin
        if (out_free) begin
          m_axis_tdata <= held;
          m_axis_tlast <= (cnt == 7'd1);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sim/tb.sv @@
// Testbench for the gaussian noise generator core: random requests against a built-in predictor.
`timescale 1ns / 1ps
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gaussian_noise_generator_core i_dut (.*);

  always #4 clk = ~clk;

  typedef struct packed {
    logic        action;
    logic [30:0] seed;
    logic [6:0]  count;
  } gen_req_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } noise_out_t;

  gen_req_t   req_q[$];
  noise_out_t sample_q[$];
  int errors = 0;
  int n_req = 0, n_samp = 0, n_reseed = 0;
  bit hold = 1'b0;
  bit done_stim = 1'b0;

  // predictor state
  logic [30:0] p_seed = 31'd1;
  logic signed [31:0] p_mean = 0;
  logic [23:0] p_scale = 24'd65536;

  function automatic logic [30:0] lcg_next(input logic [30:0] s);
    longint v, k;
    v = s;
    k = v / 127773;
    v = 16807 * (v - k * 127773) - k * 2836;
    if (v < 0) v += 2147483647;
    return v[30:0];
  endfunction

  function automatic longint unsigned neg2ln_q(input logic [30:0] s_in);
    longint unsigned m, frac, q, c, sq, s;
    int p;
    s = s_in;
    if (s == 0) s = 1;
    p = 30;
    frac = 0;
    while (p > 0 && s[p] == 1'b0) p--;
    m = s << (30 - p);
    for (int i = 0; i < 16; i++) begin
      sq = (m * m) >> 30;
      frac <<= 1;
      if (sq >= 64'd2147483648) begin
        frac |= 1;
        m = sq >> 1;
      end else begin
        m = sq;
      end
    end
    q = (longint'(31 - p) << 16) - frac;
    c = (64'd1488522236 + 64'd8192) >> 14;
    return (q >> 16) * c + (((q & 64'hFFFF) * c) >> 16);
  endfunction

  function automatic longint unsigned root_q(input longint unsigned v);
    longint unsigned rt, rem, pr, trial, b;
    rt = 0;
    rem = 0;
    for (int i = 33; i >= 0; i--) begin
      pr = 0;
      for (int k = 2 * i + 1; k >= 2 * i; k--) begin
        b = (k >= 16) ? ((v >> (k - 16)) & 1) : 0;
        pr = (pr << 1) | b;
      end
      rem = (rem << 2) | pr;
      trial = (rt << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        rt = (rt << 1) | 1;
      end else begin
        rt <<= 1;
      end
    end
    return rt;
  endfunction

  task automatic sincos_q(input logic [30:0] a, output longint cs, output longint sn);
    longint unsigned sd[4], cd[5], f, g, x, x2, t, s, c;
    logic [2:0] oct;
    longint c0, s0;
    sd = '{72, 42, 20, 6};
    cd = '{90, 56, 30, 12, 2};
    oct = a[30:28];
    f = a[27:0];
    g = oct[0] ? (64'h10000000 - f) : f;
    x = (g * 64'd3373259426) >> 30;
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    for (int i = 0; i < 4; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / sd[i];
    s = (x * t) >> 30;
    t = 64'd1073741824;
    for (int i = 0; i < 5; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / cd[i];
    c = t;
    c0 = oct[0] ? longint'(s) : longint'(c);
    s0 = oct[0] ? longint'(c) : longint'(s);
    case (oct[2:1])
      2'd0: begin cs = c0; sn = s0; end
      2'd1: begin cs = -s0; sn = c0; end
      2'd2: begin cs = -c0; sn = -s0; end
      default: begin cs = s0; sn = -c0; end
    endcase
  endtask

  function automatic logic [31:0] scaled_sample(input longint unsigned r, input longint trig);
    longint unsigned mag, z;
    longint term, res;
    mag = (trig < 0) ? longint'(-trig) : trig;
    z = (r * mag) >> 30;
    term = longint'((longint'(p_scale) * z) >> 16);
    res = longint'(p_mean) + ((trig < 0) ? -term : term);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  task automatic predict_noise(input gen_req_t r);
    int left;
    logic [30:0] u1, u2;
    longint unsigned rad;
    longint cs, sn;
    if (!r.action) begin
      p_seed = (r.seed == 0 || r.seed == 31'h7FFFFFFF) ? 31'd1 : r.seed;
      return;
    end
    left = (r.count > 64) ? 64 : r.count;
    while (left > 0) begin
      u1 = lcg_next(p_seed);
      u2 = lcg_next(u1);
      p_seed = u2;
      rad = root_q(neg2ln_q(u1));
      sincos_q(u2, cs, sn);
      left--;
      sample_q.push_back('{scaled_sample(rad, cs), left == 0});
      if (left > 0) begin
        left--;
        sample_q.push_back('{scaled_sample(rad, sn), left == 0});
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // driver
  int s_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_noise({s_axis_tuser, s_axis_tdata[30:0], s_axis_tdata[37:31]});
        s_wait <= $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (s_wait > 0) begin
          s_wait <= s_wait - 1;
        end else if (req_q.size() > 0 && !hold) begin
          s_axis_tuser <= req_q[0].action;
          s_axis_tdata <= {2'b00, req_q[0].count, req_q[0].seed};
          s_axis_tvalid <= 1'b1;
          void'(req_q.pop_front());
        end
      end
    end
  end

  // monitor
  int m_wait = 0;
  noise_out_t exp_s;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_samp++;
        if (sample_q.size() == 0) begin
          report("unexpected sample", m_axis_tdata, '0);
        end else begin
          exp_s = sample_q.pop_front();
          if (m_axis_tdata !== exp_s.sample) report("sample", m_axis_tdata, exp_s.sample);
          if (m_axis_tlast !== exp_s.last) report("tlast", m_axis_tlast, exp_s.last);
        end
        m_wait = $urandom_range(0, 8);
        m_axis_tready <= (m_wait == 0);
      end else if (m_wait > 0) begin
        m_wait--;
        m_axis_tready <= (m_wait == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc > 40000) begin
      $display("watchdog: no traffic, %0d samples pending", sample_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic gen_req_t mk_gen(input int cnt);
    return '{1'b1, 31'($urandom), 7'(cnt)};
  endfunction

  function automatic gen_req_t mk_seed(input logic [30:0] s);
    return '{1'b0, s, 7'($urandom)};
  endfunction

  task automatic drain();
    while (req_q.size() > 0 || s_axis_tvalid || sample_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gng_pkg::CFG_MEAN[0]) p_mean = val;
    else p_scale = val[23:0];
  endtask

  function automatic int pick_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return 0;
    if (k < 6) return $urandom_range(65, 127);
    if (k < 12) return 64;
    return $urandom_range(1, 9);
  endfunction

  logic [31:0] means[5];
  logic [23:0] scales[5];
  initial begin
    means = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00030000, 32'hFFF80000};
    scales = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd16384, 24'h3A5F21};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset seed, seed edge cases, counts at extremes
    req_q.push_back(mk_gen(1));
    req_q.push_back(mk_gen(2));
    req_q.push_back(mk_seed(31'd0));
    req_q.push_back(mk_gen(3));
    req_q.push_back(mk_seed(31'h7FFFFFFF));
    req_q.push_back(mk_gen(0));
    req_q.push_back(mk_gen(4));
    req_q.push_back(mk_seed(31'h7FFFFFFE));
    req_q.push_back(mk_gen(5));
    req_q.push_back(mk_seed(31'h55555555));
    req_q.push_back(mk_gen(127));
    req_q.push_back(mk_seed(31'h2AAAAAAA));
    req_q.push_back(mk_gen(64));
    req_q.push_back(mk_gen(65));
    req_q.push_back(mk_seed(31'd1));
    req_q.push_back(mk_gen(7));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(gng_pkg::CFG_MEAN[0], (ph < 5) ? means[ph] : $urandom);
      write_cfg(gng_pkg::CFG_SCALE[0],
        (ph < 5) ? 32'(scales[ph]) : 32'($urandom_range(0, 24'hFFFFFF)));
      for (int i = 0; i < 49; i++) begin
        if ($urandom_range(0, 3) == 0) req_q.push_back(mk_seed(31'($urandom)));
        else req_q.push_back(mk_gen(pick_count()));
      end
      if (ph == 2) begin
        // sender holds off until the block has drained completely
        while (req_q.size() > 25) @(posedge clk);
        hold = 1'b1;
        while (s_axis_tvalid || sample_q.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        hold = 1'b0;
      end
      drain();
    end
    write_cfg(gng_pkg::CFG_MEAN[0], 32'h0);
    write_cfg(gng_pkg::CFG_SCALE[0], 32'd65536);
    req_q.push_back(mk_gen(9));
    drain();

    $display("covered %0d samples over six mean/scale settings incl. saturating extremes",
      n_samp);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
